// ===== rtl/lpcp_pkg.sv =====
// Package for the lidar point camera projection core.
// Holds field widths, status and register codes and the structs; the interfaces,
// the quotient pipeline and the top level use them. Depends on nothing.
package lpcp_pkg;

  localparam int FIELD_W    = 32;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DEPTH_ZERO = 2'd1,
    ST_SAT        = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5
  } cfg_reg_e;

  // sideband that travels with a point through the quotient pipeline
  typedef struct packed {
    logic       last;
    logic       zero;
    logic       d_sat;
    logic [1:0] neg;
    logic [1:0] ovf;
  } flags_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_u;
    logic [FIELD_W-1:0] pixel_v;
    logic [FIELD_W-1:0] point_depth;
    status_e            status;
    logic               last_out;
  } res_t;

endpackage

// ===== rtl/lpcp_if.sv =====
// Valid/ready channels of the projection core: point in, result out and
// register write. Depends on lpcp_pkg for field widths and codes.
interface lpcp_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpcp_pkg::FIELD_W-1:0] point_x;
  logic signed [lpcp_pkg::FIELD_W-1:0] point_y;
  logic signed [lpcp_pkg::FIELD_W-1:0] point_z;
  logic                               last_in_cloud;

  modport source (output valid, point_x, point_y, point_z, last_in_cloud, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_in_cloud, output ready);
endinterface

interface lpcp_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpcp_pkg::FIELD_W-1:0] pixel_u;
  logic signed [lpcp_pkg::FIELD_W-1:0] pixel_v;
  logic signed [lpcp_pkg::FIELD_W-1:0] point_depth;
  lpcp_pkg::status_e                  status;
  logic                               last_out;

  modport source (output valid, pixel_u, pixel_v, point_depth, status, last_out, input ready);
  modport sink (input valid, pixel_u, pixel_v, point_depth, status, last_out, output ready);
endinterface

interface lpcp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lpcp_pkg::CFG_IDX_W-1:0]    index;
  logic [lpcp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lpcp_div.sv =====
// Quotient pipeline: restoring division of two magnitudes by one divisor,
// one quotient bit per register stage. Depends on lpcp_pkg for flags_t.
module lpcp_div #(
  parameter int VW = 32,
  parameter int DW = 51
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DW-1:0]          rem_i [2],
  input  logic [VW:0]            num_i [2],
  input  logic [DW-1:0]          dm_i,
  input  lpcp_pkg::flags_t       flg_i,
  input  logic [VW-1:0]          dep_i,
  output logic                   valid_o,
  output logic [VW:0]            quo_o [2],
  output lpcp_pkg::flags_t       flg_o,
  output logic [VW-1:0]          dep_o
);

  localparam int QW = VW + 1;

  logic             v_q   [QW];
  logic [DW-1:0]    rem_q [QW][2];
  logic [QW-1:0]    lq_q  [QW][2];
  logic [DW-1:0]    dm_q  [QW];
  lpcp_pkg::flags_t flg_q [QW];
  logic [VW-1:0]    dep_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic             v_s;
    logic [DW-1:0]    rem_s [2];
    logic [QW-1:0]    lq_s  [2];
    logic [DW-1:0]    dm_s;
    lpcp_pkg::flags_t flg_s;
    logic [VW-1:0]    dep_s;
    logic [DW:0]      trial [2];
    logic [DW:0]      diff  [2];
    logic [1:0]       ge;
    logic [DW-1:0]    rem_d [2];
    logic [QW-1:0]    lq_d  [2];

    if (j == 0) begin : g_src_in
      assign v_s   = valid_i;
      assign rem_s = rem_i;
      assign lq_s  = num_i;
      assign dm_s  = dm_i;
      assign flg_s = flg_i;
      assign dep_s = dep_i;
    end else begin : g_src_prev
      assign v_s   = v_q[j-1];
      assign rem_s = rem_q[j-1];
      assign lq_s  = lq_q[j-1];
      assign dm_s  = dm_q[j-1];
      assign flg_s = flg_q[j-1];
      assign dep_s = dep_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < 2; i++) begin
        trial[i] = {rem_s[i], lq_s[i][QW-1]};
        ge[i]    = trial[i] >= {1'b0, dm_s};
        diff[i]  = trial[i] - {1'b0, dm_s};
        rem_d[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
        lq_d[i]  = {lq_s[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 2; i++) begin
          rem_q[j][i] <= rem_d[i];
          lq_q[j][i]  <= lq_d[i];
        end
        dm_q[j]  <= dm_s;
        flg_q[j] <= flg_s;
        dep_q[j] <= dep_s;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = lq_q[QW-1];
  assign flg_o   = flg_q[QW-1];
  assign dep_o   = dep_q[QW-1];

`ifndef SYNTH
  a_rem_u_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] && !flg_q[QW-1].zero && !flg_q[QW-1].ovf[0] |->
      rem_q[QW-1][0] < dm_q[QW-1])
    else $error("u remainder not below divisor");
  a_rem_v_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] && !flg_q[QW-1].zero && !flg_q[QW-1].ovf[1] |->
      rem_q[QW-1][1] < dm_q[QW-1])
    else $error("v remainder not below divisor");
`endif

endmodule

// ===== rtl/lidar_point_camera_projection_core.sv =====
// Top level of the lidar point camera projection core: 3x4 matrix product,
// depth rounding, quotient pipeline and output skid buffer.
// Depends on lpcp_pkg, the lpcp_*_if interfaces and lpcp_div.
//
//  channel    | dir | word
//  point_i    | in  | point_x, point_y, point_z, last_in_cloud
//  result_o   | out | pixel_u, pixel_v, point_depth, status, last_out
//  cfg_i      | in  | index (row coefficient pair), data (two Q halves)
//
// One point per cycle while the skid buffer is not full; a point passes through
// five product/sum stages, VALUE_WIDTH + 1 stages of one quotient bit each and
// the output buffer register.
// Output goes through a two word skid buffer; the pipeline holds as a whole
// while the buffer is full, so a stall loses and repeats nothing.
// Reset clears valid bits, buffer pointers and coefficients.
module lidar_point_camera_projection_core #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpcp_point_if.sink    point_i,
  lpcp_result_if.source result_o,
  lpcp_cfg_if.sink      cfg_i
);

  localparam int VW = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * VW;
  localparam int SW = 2 * VW + 3;
  localparam int DW = SW - F;
  localparam int QW = VW + 1;
  localparam int HW = SW - QW;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int FW = lpcp_pkg::FIELD_W;
  localparam int HF = lpcp_pkg::HALF_W;

  localparam logic signed [SW-1:0] RND    = SW'(1) << (F - 1);
  localparam logic [VW-1:0]        VMIN   = {1'b1, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0]        VMAX   = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [QW-1:0]        Q_LIM  = QW'(1) << (VW - 1);
  localparam logic [QW-1:0]        Q_MAXP = Q_LIM - QW'(1);

  // coefficients
  logic signed [VW-1:0] coef_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          coef_q[r][c] <= '0;
        end
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (lpcp_pkg::cfg_reg_e'(cfg_i.index))
        lpcp_pkg::REG_ROW0_A: begin
          coef_q[0][0] <= cfg_i.data[VW-1:0];
          coef_q[0][1] <= cfg_i.data[HF +: VW];
        end
        lpcp_pkg::REG_ROW0_B: begin
          coef_q[0][2] <= cfg_i.data[VW-1:0];
          coef_q[0][3] <= cfg_i.data[HF +: VW];
        end
        lpcp_pkg::REG_ROW1_A: begin
          coef_q[1][0] <= cfg_i.data[VW-1:0];
          coef_q[1][1] <= cfg_i.data[HF +: VW];
        end
        lpcp_pkg::REG_ROW1_B: begin
          coef_q[1][2] <= cfg_i.data[VW-1:0];
          coef_q[1][3] <= cfg_i.data[HF +: VW];
        end
        lpcp_pkg::REG_ROW2_A: begin
          coef_q[2][0] <= cfg_i.data[VW-1:0];
          coef_q[2][1] <= cfg_i.data[HF +: VW];
        end
        lpcp_pkg::REG_ROW2_B: begin
          coef_q[2][2] <= cfg_i.data[VW-1:0];
          coef_q[2][3] <= cfg_i.data[HF +: VW];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // pipeline control
  logic [1:0] cnt_q;
  logic       en;
  logic [4:0] sv_q;

  assign en            = (cnt_q != 2'd2);
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[3:0], point_i.valid};
    end
  end

  // stage 1: products
  logic signed [VW-1:0] pt [3];
  logic signed [PW-1:0] p1_d [3][3];
  logic signed [SW-1:0] k1_d [3];
  logic signed [PW-1:0] p1_q [3][3];
  logic signed [SW-1:0] k1_q [3];
  logic                 l1_q;

  always_comb begin
    pt[0] = point_i.point_x[VW-1:0];
    pt[1] = point_i.point_y[VW-1:0];
    pt[2] = point_i.point_z[VW-1:0];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p1_d[r][c] = coef_q[r][c] * pt[c];
      end
      k1_d[r] = SW'(coef_q[r][3]) <<< F;
    end
  end

  // stage 2 and 3: row sums, row 2 carries the rounding half
  logic signed [SW-1:0] a2_q [3];
  logic signed [SW-1:0] b2_q [3];
  logic signed [SW-1:0] s3_q [3];
  logic                 l2_q;
  logic                 l3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      k1_q <= k1_d;
      l1_q <= point_i.last_in_cloud;
      for (int r = 0; r < 3; r++) begin
        a2_q[r] <= SW'(p1_q[r][0]) + SW'(p1_q[r][1]);
        b2_q[r] <= SW'(p1_q[r][2]) + k1_q[r] + ((r == 2) ? RND : SW'(0));
        s3_q[r] <= a2_q[r] + b2_q[r];
      end
      l2_q <= l1_q;
      l3_q <= l2_q;
    end
  end

  // stage 4: depth, magnitudes, signs
  logic signed [DW-1:0] d_w;
  logic [DW-1:0]        dm_w;
  logic [SW-1:0]        nm_w [2];
  logic                 dsat_w;
  logic [VW-1:0]        dep_w;
  lpcp_pkg::flags_t     flg4_d;

  always_comb begin
    d_w    = s3_q[2][SW-1:F];
    dm_w   = d_w[DW-1] ? DW'(-d_w) : DW'(d_w);
    dsat_w = !((&d_w[DW-1:VW-1]) || !(|d_w[DW-1:VW-1]));
    dep_w  = dsat_w ? (d_w[DW-1] ? VMIN : VMAX) : d_w[VW-1:0];
    flg4_d = '0;
    flg4_d.last  = l3_q;
    flg4_d.zero  = (d_w == '0);
    flg4_d.d_sat = dsat_w;
    for (int i = 0; i < 2; i++) begin
      nm_w[i]       = s3_q[i][SW-1] ? SW'(-s3_q[i]) : SW'(s3_q[i]);
      flg4_d.neg[i] = s3_q[i][SW-1] ^ d_w[DW-1];
    end
  end

  logic [SW-1:0]    nm4_q [2];
  logic [DW-1:0]    dm4_q;
  lpcp_pkg::flags_t flg4_q;
  logic [VW-1:0]    dep4_q;

  // stage 5: overflow test and divider seed
  logic [HW-1:0]    hi_w  [2];
  logic [DW-1:0]    rem5_d [2];
  logic [QW-1:0]    low5_d [2];
  lpcp_pkg::flags_t flg5_d;

  always_comb begin
    flg5_d = flg4_q;
    for (int i = 0; i < 2; i++) begin
      hi_w[i]       = nm4_q[i][SW-1:QW];
      flg5_d.ovf[i] = CW'(hi_w[i]) >= CW'(dm4_q);
      rem5_d[i]     = DW'(hi_w[i]);
      low5_d[i]     = nm4_q[i][QW-1:0];
    end
  end

  logic [DW-1:0]    rem5_q [2];
  logic [QW-1:0]    low5_q [2];
  logic [DW-1:0]    dm5_q;
  lpcp_pkg::flags_t flg5_q;
  logic [VW-1:0]    dep5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm4_q  <= nm_w;
      dm4_q  <= dm_w;
      flg4_q <= flg4_d;
      dep4_q <= dep_w;
      rem5_q <= rem5_d;
      low5_q <= low5_d;
      dm5_q  <= dm4_q;
      flg5_q <= flg5_d;
      dep5_q <= dep4_q;
    end
  end

  // quotient pipeline
  logic             dv;
  logic [QW-1:0]    dq [2];
  lpcp_pkg::flags_t dflg;
  logic [VW-1:0]    ddep;
  logic [VW-1:0]    ddep_in_w;

  assign ddep_in_w = dep5_q;

  lpcp_div #(
    .VW (VW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[4]),
    .rem_i   (rem5_q),
    .num_i   (low5_q),
    .dm_i    (dm5_q),
    .flg_i   (flg5_q),
    .dep_i   (ddep_in_w),
    .valid_o (dv),
    .quo_o   (dq),
    .flg_o   (dflg),
    .dep_o   (ddep)
  );

  // sign, saturation and status
  logic signed [VW-1:0] qv [2];
  logic [1:0]           qsat;
  lpcp_pkg::res_t       res_d;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (dflg.neg[i]) begin
        qsat[i] = dflg.ovf[i] || (dq[i] > Q_LIM);
        qv[i]   = qsat[i] ? VMIN : VW'(-dq[i]);
      end else begin
        qsat[i] = dflg.ovf[i] || (dq[i] > Q_MAXP);
        qv[i]   = qsat[i] ? VMAX : dq[i][VW-1:0];
      end
    end
    res_d.last_out = dflg.last;
    if (dflg.zero) begin
      res_d.pixel_u     = '0;
      res_d.pixel_v     = '0;
      res_d.point_depth = '0;
      res_d.status      = lpcp_pkg::ST_DEPTH_ZERO;
    end else begin
      res_d.pixel_u     = FW'(qv[0]);
      res_d.pixel_v     = FW'(qv[1]);
      res_d.point_depth = FW'(signed'(ddep));
      res_d.status      = (|qsat || dflg.d_sat) ? lpcp_pkg::ST_SAT : lpcp_pkg::ST_OK;
    end
  end

  // output skid buffer
  lpcp_pkg::res_t buf_q [2];
  logic           wr_q;
  logic           rd_q;
  logic           push;
  logic           pop;

  assign push = en && dv;
  assign pop  = result_o.valid && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res_d;
    end
  end

  assign result_o.valid       = (cnt_q != 2'd0);
  assign result_o.pixel_u     = buf_q[rd_q].pixel_u;
  assign result_o.pixel_v     = buf_q[rd_q].pixel_v;
  assign result_o.point_depth = buf_q[rd_q].point_depth;
  assign result_o.status      = buf_q[rd_q].status;
  assign result_o.last_out    = buf_q[rd_q].last_out;

`ifndef SYNTH
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cnt_q[1] && cnt_q[0]))
    else $error("skid buffer count beyond two words");
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.status == lpcp_pkg::ST_DEPTH_ZERO |->
      result_o.pixel_u == '0 && result_o.pixel_v == '0 && result_o.point_depth == '0)
    else $error("zero depth word with non-zero fields");
  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sv_q))
    else $error("pipeline valid bits moved while held");
`endif

endmodule
